/* sv/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define OLS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define OLS_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ols_pkg.sv */
// Types and constants of the ordered list store.
package ols_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int LEN_W = 7;
  localparam int IN_W  = 40;
  localparam int OUT_W = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } ols_op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } ols_status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } ols_state_t;

endpackage

/* sv/ordered_list_store.sv */
// Ordered list store: top level with command sequencer and output register.
//
// Keeps up to CAPACITY signed 32-bit values in insertion order in one
// single-port-write, single-port-read memory. One command is taken at a time.
// An insert, an unused opcode, or a search or delete on an empty list needs
// no walk of the list. A search or delete walks the list from the head
// reading one entry per cycle; a delete closes the gap in the same walk
// by writing each later entry one place down as it is read. A search stops
// at the entry that it hits; a delete or a missed search walks on to the
// tail. A finished result waits in the output register while the next
// command is taken. No clearing pass is needed after reset.
module ordered_list_store #(
  parameter int CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // opcode [1:0], value [33:2], zero [39:34]
  input  logic [ols_pkg::IN_W-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // status [1:0], found [2], position [8:3], length [15:9]
  output logic [ols_pkg::OUT_W-1:0] out_tdata
);
  import ols_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  ols_state_t        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     ridx_r, ridx_nxt;
  logic              hit_r, hit_nxt;
  logic [1:0]        op_r;
  logic [VAL_W-1:0]  val_r;
  ols_status_t       res_status_r, res_status_nxt;
  logic              res_found_r, res_found_nxt;
  logic [AW-1:0]     res_pos_r, res_pos_nxt;
  logic              out_tvalid_r;
  logic [OUT_W-1:0]  out_tdata_r;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [VAL_W-1:0]  wdata, rdata;

  logic              accept, list_empty, list_full, is_last, match, scan_end, out_load;
  logic [1:0]        in_op;
  logic [VAL_W-1:0]  in_val;

  assign in_op      = in_tdata[1:0];
  assign in_val     = in_tdata[VAL_W+1:2];
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign list_empty = (count_r == '0);
  assign list_full  = (count_r == CAP_C);
  assign is_last    = (CW'(ridx_r) == count_r - CW'(1));
  assign match      = (rdata == val_r);
  // A search stops at its first match; a delete runs to the tail to compact.
  assign scan_end   = (match && !hit_r && op_r == OP_SEARCH) || is_last;
  assign out_load   = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  ols_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if ((in_op == OP_DELETE || in_op == OP_SEARCH) && !list_empty) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory controls, count and result.
  always_comb begin
    count_nxt      = count_r;
    ridx_nxt       = ridx_r;
    hit_nxt        = hit_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_pos_nxt    = res_pos_r;
    we             = 1'b0;
    waddr          = ridx_r - AW'(1);
    wdata          = rdata;
    re             = 1'b0;
    raddr          = ridx_r + AW'(1);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          case (in_op)
            OP_INSERT: begin
              if (list_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                we             = 1'b1;
                waddr          = count_r[AW-1:0];
                wdata          = in_val;
                count_nxt      = count_r + CW'(1);
                res_status_nxt = ST_DONE;
              end
            end
            OP_DELETE, OP_SEARCH: begin
              if (list_empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                re             = 1'b1;
                raddr          = '0;
                ridx_nxt       = '0;
                hit_nxt        = 1'b0;
                res_status_nxt = ST_ABSENT;
              end
            end
            default: res_status_nxt = ST_DONE;
          endcase
        end
      end
      S_SCAN: begin
        // Once the match is behind us every entry read moves one place down.
        if (hit_r) begin
          we = 1'b1;
        end
        if (!hit_r && match) begin
          hit_nxt        = 1'b1;
          res_found_nxt  = 1'b1;
          res_pos_nxt    = ridx_r;
          res_status_nxt = ST_DONE;
        end
        if (is_last && (hit_r || (match && op_r == OP_DELETE))) begin
          count_nxt = count_r - CW'(1);
        end
        if (!scan_end) begin
          re       = 1'b1;
          ridx_nxt = ridx_r + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx_r       <= ridx_nxt;
    hit_r        <= hit_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_pos_r    <= res_pos_nxt;
    if (accept) begin
      op_r  <= in_op;
      val_r <= in_val;
    end
    if (out_load) begin
      out_tdata_r <= {LEN_W'(count_r), POS_W'(res_pos_r), res_found_r, res_status_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* sv/ols_mem.sv */
// Entry memory: one write port and one read port with registered read data.
module ols_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [ols_pkg::VAL_W-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic [ols_pkg::VAL_W-1:0] rdata
);
  import ols_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/ols_checker.sv */
// Port-level checker of the ordered list store and its bind.
`include "assert_macros.svh"

module ols_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [ols_pkg::OUT_W-1:0] out_tdata
);
  import ols_pkg::*;

  logic [1:0] status;
  logic       found;
  logic [5:0] position;
  logic [6:0] length;

  assign status   = out_tdata[1:0];
  assign found    = out_tdata[2];
  assign position = out_tdata[8:3];
  assign length   = out_tdata[15:9];

  `OLS_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_tvalid && in_tready, "not idle after reset")
  `OLS_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `OLS_ASSERT(a_found_done, clk, rst_n, out_tvalid && found |-> status == ST_DONE, "match reported with failure status")
  `OLS_ASSERT(a_pos_found, clk, rst_n, out_tvalid && !found |-> position == 6'd0, "position given without match")
  `OLS_ASSERT(a_empty_len, clk, rst_n, out_tvalid && status == ST_EMPTY |-> length == 7'd0, "empty status with entries left")

endmodule

bind ordered_list_store ols_checker u_ols_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* test/tb.sv */
// Self-checking testbench for the ordered list store.
`timescale 1ns / 1ps

module tb;
  import ols_pkg::*;

  localparam int CAPACITY = 64;
  localparam int RANDOM_ITEMS = 1550;
  localparam int DIR_ROWS = 23;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Matches the packing of out_tdata, lowest field last.
  typedef struct packed {
    logic [6:0]  length;
    logic [5:0]  position;
    logic        found;
    ols_status_t status;
  } list_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] val;
    logic        typed;
    logic [15:0] want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // opcode [1:0], value [33:2], zero [39:34]
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // status [1:0], found [2], position [8:3], length [15:9]
  logic [OUT_W-1:0] out_tdata;

  logic [31:0]  list_q[$];
  list_result_t result_q[$];
  int           err_count = 0;
  bit           calm = 1'b0;

  // Rows with a typed result can be read straight off the list contents;
  // the rest are left to the predictor.
  stim_row_t dir_tab [DIR_ROWS] = '{
    '{OP_SEARCH, 32'h0000_0000, 1'b1, {7'd0, 6'd0, 1'b0, ST_EMPTY}},
    '{OP_DELETE, 32'h0000_0000, 1'b1, {7'd0, 6'd0, 1'b0, ST_EMPTY}},
    '{OP_UNUSED, 32'h0000_0000, 1'b1, {7'd0, 6'd0, 1'b0, ST_DONE}},
    '{OP_INSERT, 32'h8000_0000, 1'b1, {7'd1, 6'd0, 1'b0, ST_DONE}},
    '{OP_INSERT, 32'h7fff_ffff, 1'b1, {7'd2, 6'd0, 1'b0, ST_DONE}},
    '{OP_INSERT, 32'hffff_ffff, 1'b1, {7'd3, 6'd0, 1'b0, ST_DONE}},
    '{OP_INSERT, 32'h0000_0000, 1'b1, {7'd4, 6'd0, 1'b0, ST_DONE}},
    '{OP_INSERT, 32'h7fff_ffff, 1'b1, {7'd5, 6'd0, 1'b0, ST_DONE}},
    '{OP_SEARCH, 32'h7fff_ffff, 1'b0, 16'h0},
    '{OP_SEARCH, 32'h0000_0000, 1'b0, 16'h0},
    '{OP_SEARCH, 32'h7fff_fffe, 1'b1, {7'd5, 6'd0, 1'b0, ST_ABSENT}},
    '{OP_DELETE, 32'h8000_0001, 1'b1, {7'd5, 6'd0, 1'b0, ST_ABSENT}},
    '{OP_DELETE, 32'h7fff_ffff, 1'b0, 16'h0},
    '{OP_SEARCH, 32'h7fff_ffff, 1'b0, 16'h0},
    '{OP_DELETE, 32'h7fff_ffff, 1'b0, 16'h0},
    '{OP_INSERT, 32'h0000_0005, 1'b0, 16'h0},
    '{OP_SEARCH, 32'h0000_0005, 1'b0, 16'h0},
    '{OP_UNUSED, 32'hffff_ffff, 1'b0, 16'h0},
    '{OP_DELETE, 32'h8000_0000, 1'b0, 16'h0},
    '{OP_DELETE, 32'hffff_ffff, 1'b0, 16'h0},
    '{OP_DELETE, 32'h0000_0000, 1'b0, 16'h0},
    '{OP_DELETE, 32'h0000_0005, 1'b0, 16'h0},
    '{OP_SEARCH, 32'h0000_0005, 1'b1, {7'd0, 6'd0, 1'b0, ST_EMPTY}}
  };

  ordered_list_store #(.CAPACITY(CAPACITY)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one command to the predicted list and returns its result.
  function automatic list_result_t apply_list_cmd(logic [1:0] op, logic [31:0] val);
    list_result_t r;
    int           hit;
    r = '0;
    r.status = ST_DONE;
    hit = -1;
    case (op)
      OP_INSERT: begin
        if (list_q.size() >= CAPACITY) r.status = ST_FULL;
        else list_q.push_back(val);
      end
      OP_DELETE, OP_SEARCH: begin
        if (list_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < list_q.size() && hit < 0; i++)
            if (list_q[i] == val) hit = i;
          if (hit < 0) begin
            r.status = ST_ABSENT;
          end else begin
            r.found = 1'b1;
            r.position = hit[5:0];
            if (op == OP_DELETE) list_q.delete(hit);
          end
        end
      end
      default: ;
    endcase
    r.length = 7'(list_q.size());
    return r;
  endfunction

  // Offers one command after a random gap (none while calm) and records its
  // expected result once the transaction completes.
  task automatic send_cmd(logic [1:0] op, logic [31:0] val, logic typed, logic [15:0] want);
    int           gap;
    list_result_t r;
    gap = 0;
    if (!calm)
      while ($urandom_range(99) < 37) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, val, op};
    do @(posedge clk); while (!in_tready);
    r = apply_list_cmd(op, val);
    result_q.push_back(typed ? list_result_t'(want) : r);
  endtask

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 37);
  end

  always @(posedge clk) begin
    list_result_t got;
    list_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = list_result_t'(out_tdata);
      if (result_q.size() == 0) begin
        $display("%0t: result %h arrived with none expected", $time, out_tdata);
        err_count++;
      end else begin
        exp_r = result_q.pop_front();
        if (got.status != exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
          err_count++;
        end
        if (got.found != exp_r.found) begin
          $display("%0t: found expected %0d actual %0d", $time, exp_r.found, got.found);
          err_count++;
        end
        if (got.position != exp_r.position) begin
          $display("%0t: position expected %0d actual %0d", $time, exp_r.position,
                   got.position);
          err_count++;
        end
        if (got.length != exp_r.length) begin
          $display("%0t: length expected %0d actual %0d", $time, exp_r.length, got.length);
          err_count++;
        end
      end
    end
  end

  initial begin
    int          mode;
    int          pick;
    logic [1:0]  op;
    logic [31:0] val;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_cmd(dir_tab[i].op, dir_tab[i].val, dir_tab[i].typed, dir_tab[i].want);

    // Each phase picks at random between filling the list to full, draining it to
    // empty and a balanced mix, so every status keeps turning up.
    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) mode = $urandom_range(2);
      calm <= (n >= 700 && n < 900);
      pick = $urandom_range(99);
      case (mode)
        0:       op = (pick < 70) ? OP_INSERT : (pick < 82) ? OP_DELETE :
                      (pick < 97) ? OP_SEARCH : OP_UNUSED;
        1:       op = (pick < 15) ? OP_INSERT : (pick < 70) ? OP_DELETE :
                      (pick < 96) ? OP_SEARCH : OP_UNUSED;
        default: op = (pick < 35) ? OP_INSERT : (pick < 65) ? OP_DELETE :
                      (pick < 96) ? OP_SEARCH : OP_UNUSED;
      endcase
      pick = $urandom_range(99);
      if (op != OP_INSERT && list_q.size() > 0 && pick < 40) begin
        val = list_q[$urandom_range(list_q.size() - 1)];
      end else if (pick < 80) begin
        case ($urandom_range(7))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7fff_ffff;
          2:       val = 32'hffff_ffff;
          3:       val = 32'h0000_0000;
          default: val = $urandom_range(4);
        endcase
      end else begin
        val = $urandom;
      end
      send_cmd(op, val, 1'b0, 16'h0);
    end
    in_tvalid <= 1'b0;
    calm <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("ordered_list_store: match");
    end else begin
      $display("ordered_list_store: mismatch");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("ordered_list_store: mismatch");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/ols_pkg.sv
sv/ols_mem.sv
sv/ordered_list_store.sv
sv/ols_checker.sv
test/tb.sv
